### hdl/i2cpio_pkg.sv
// Shared types, microcode format and entry points for the I2C pin sequencer.
package i2cpio_pkg;

	typedef struct packed {
		logic [1:0] func;
		logic [8:0] data_word;
	} in_item_t;

	typedef struct packed {
		logic       sda;
		logic       scl;
		logic [7:0] pio_byte;
		logic [7:0] pio_byte_complement;
		logic       last;
	} out_item_t;

	localparam logic [1:0] FUNC_DATA  = 2'd0;
	localparam logic [1:0] FUNC_START = 2'd1;
	localparam logic [1:0] FUNC_STOP  = 2'd2;

	localparam int PC_W = 4;
	localparam logic [PC_W-1:0] PC_START = 4'd0;
	localparam logic [PC_W-1:0] PC_STOP  = 4'd4;
	localparam logic [PC_W-1:0] PC_DATA  = 4'd6;

	localparam logic [5:0] PIO_HIGH = 6'b111111;

	typedef enum logic [1:0] {
		SDA_ZERO,
		SDA_ONE,
		SDA_BIT,
		SDA_REL
	} sda_sel_t;

	typedef struct packed {
		sda_sel_t        sda_sel;
		logic            scl;
		logic            last;
		logic            rot;
		logic            loop_bits;
		logic [PC_W-1:0] target;
	} ucode_t;

	typedef struct packed {
		logic       load;
		logic       fire;
		logic [8:0] word;
		logic       release_bit;
	} ctl_t;

	typedef struct packed {
		logic bits_done;
	} sta_t;

endpackage

### hdl/i2cpio_rom.sv
// Microcode table: one control word per pin state of each operation.
module i2cpio_rom
	import i2cpio_pkg::*;
(
	input  logic [PC_W-1:0] pc,
	output ucode_t          uc
);

	always_comb begin
		uc = '{sda_sel: SDA_ZERO, scl: 1'b0, last: 1'b1, rot: 1'b0,
			loop_bits: 1'b0, target: PC_START};
		case (pc)
			// start: forced stop, then start
			4'd0: uc = '{SDA_ZERO, 1'b1, 1'b0, 1'b0, 1'b0, PC_START};
			4'd1: uc = '{SDA_ONE,  1'b1, 1'b0, 1'b0, 1'b0, PC_START};
			4'd2: uc = '{SDA_ZERO, 1'b1, 1'b0, 1'b0, 1'b0, PC_START};
			4'd3: uc = '{SDA_ZERO, 1'b0, 1'b1, 1'b0, 1'b0, PC_START};
			// stop
			4'd4: uc = '{SDA_ZERO, 1'b1, 1'b0, 1'b0, 1'b0, PC_START};
			4'd5: uc = '{SDA_ONE,  1'b1, 1'b1, 1'b0, 1'b0, PC_START};
			// data bits, looped eight times
			4'd6: uc = '{SDA_BIT,  1'b0, 1'b0, 1'b0, 1'b0, PC_START};
			4'd7: uc = '{SDA_BIT,  1'b1, 1'b0, 1'b0, 1'b0, PC_START};
			4'd8: uc = '{SDA_REL,  1'b0, 1'b0, 1'b1, 1'b1, PC_DATA};
			// acknowledge bit
			4'd9:  uc = '{SDA_BIT, 1'b0, 1'b0, 1'b0, 1'b0, PC_START};
			4'd10: uc = '{SDA_BIT, 1'b1, 1'b0, 1'b0, 1'b0, PC_START};
			4'd11: uc = '{SDA_BIT, 1'b0, 1'b1, 1'b0, 1'b0, PC_START};
			default: uc = '{SDA_ZERO, 1'b0, 1'b1, 1'b0, 1'b0, PC_START};
		endcase
	end

endmodule

### hdl/i2cpio_datapath.sv
// Bit rotator, bit counter and output register driven by the microcode word.
module i2cpio_datapath
	import i2cpio_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  ctl_t      ctl,
	input  ucode_t    uc,
	input  logic      out_stall,
	output logic      out_valid,
	output out_item_t out_item,
	output sta_t      sta
);

	logic [8:0] sh_q;
	logic [2:0] cnt_q;
	logic       out_valid_q;
	out_item_t  out_q;
	logic       sda;
	logic [7:0] pio;

	always_comb begin
		case (uc.sda_sel)
			SDA_ZERO: sda = 1'b0;
			SDA_ONE:  sda = 1'b1;
			SDA_BIT:  sda = sh_q[7];
			SDA_REL:  sda = ctl.release_bit | sh_q[7];
			default:  sda = 1'b0;
		endcase
	end

	assign pio = {PIO_HIGH, sda, uc.scl};

	// rotate so the acknowledge bit lands in bit 7 after the eighth data bit
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			sh_q  <= ctl.word;
			cnt_q <= '0;
		end else if (ctl.fire) begin
			if (uc.rot)
				sh_q <= {sh_q[7:0], sh_q[8]};
			if (uc.loop_bits)
				cnt_q <= cnt_q + 3'd1;
		end
		if (ctl.fire)
			out_q <= '{sda: sda, scl: uc.scl, pio_byte: pio,
				pio_byte_complement: ~pio, last: uc.last};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_item      = out_q;
	assign sta.bits_done = (cnt_q == 3'd7);

endmodule

### hdl/i2c_op_to_pio_pin_sequencer.sv
// Top level: I2C operation to SCL/SDA pin-state sequencer.
// Usage:
//   Input channel (in_valid/in_stall, in_item) takes one I2C operation:
//   func 1 start, 2 stop, anything else a 9-bit data word (data MSB first,
//   then the acknowledge bit in data_word[8]).
//   Output channel (out_valid/out_stall, out_item) gives one pin state per
//   item with its PIO byte, the byte's complement and a last flag.
//   A start gives 4 items, a stop 2, a data word 27.
//   The microcode program counter steps once per cycle while the output
//   register is free, so one item leaves per cycle; the program counter
//   takes the entry address at acceptance and the output register then
//   takes the first state. busy clears on the edge on which the last
//   state enters the output register, so the next operation can be
//   accepted while that state may still wait to be taken.
//   in_stall is high while an operation is being sequenced.
//   out_stall, while out_valid is high, holds the output register and freezes the program counter.
//   wr_en/wr_data set sda_release_after_bit; write it only when idle.
//   Reset clears the register, the sequencer and the output valid.
module i2c_op_to_pio_pin_sequencer
	import i2cpio_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_en,
	input  logic      wr_data,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	logic            busy_q;
	logic            release_q;
	logic [PC_W-1:0] pc_q;
	logic            accept;
	logic            fire;
	logic [PC_W-1:0] entry;
	ucode_t          uc;
	ctl_t            ctl;
	sta_t            sta;

	assign in_stall = busy_q;
	assign accept   = in_valid && !busy_q;
	assign fire     = busy_q && (!out_valid || !out_stall);

	always_comb begin
		case (in_item.func)
			FUNC_START: entry = PC_START;
			FUNC_STOP:  entry = PC_STOP;
			default:    entry = PC_DATA;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			release_q <= 1'b0;
		end else if (wr_en) begin
			release_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= PC_START;
		end else if (accept) begin
			busy_q <= 1'b1;
			pc_q   <= entry;
		end else if (fire) begin
			if (uc.last)
				busy_q <= 1'b0;
			// loop back until all eight data bits are out
			if (uc.loop_bits && !sta.bits_done)
				pc_q <= uc.target;
			else
				pc_q <= pc_q + 4'd1;
		end
	end

	assign ctl = '{load: accept, fire: fire, word: in_item.data_word,
		release_bit: release_q};

	i2cpio_rom u_rom (
		.pc (pc_q),
		.uc (uc)
	);

	i2cpio_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.uc        (uc),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_item  (out_item),
		.sta       (sta)
	);

endmodule
